// ===== rtl/dpalu_pkg.sv =====
// ----------------------------------------------------------------------------
// dpalu_pkg: shared types and codes for the data-processing alu
// Command codes, opcodes, shift kinds and the records passed between the
// shifter, the alu and the top level.
// ----------------------------------------------------------------------------
package dpalu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned NumRegs = 16;

  // reg_index value that selects the status word
  localparam logic [4:0] STATUS_IDX = 5'd16;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  // data-processing opcodes handled here
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_res_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
    logic             writes_rd;
    logic             supported;
  } alu_res_t;

endpackage

// ===== rtl/data_processing_alu_with_shifter.sv =====
// ----------------------------------------------------------------------------
// data_processing_alu_with_shifter: execute stage with barrel shifter
// Runs one data-processing instruction, or a register / status write or
// read, per transfer against a sixteen-entry register file and nzcv flags.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_      | in  | in_tvalid/tready   | tuser: command; tdata: instr, idx, wdata
//  out_     | out | out_tvalid/tready  | tdata: result, rd, written, nzcv, unsup
//
//  one transfer in and one result out per clock when neither side stalls
//  register file read goes into the stage register, then shifter, alu
//  and flag logic go into the output register
//  the register file is two copies of a 16x32 memory with write-first
//  bypass, so back-to-back dependent instructions see the newest value
//  synchronous active-low reset clears valid flags, the status word and
//  the register file valid bits (unwritten registers read as zero)
//  a stalled output holds its result; the stage register keeps taking a
//  transfer while the output register is free or being drained
//
module data_processing_alu_with_shifter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [71:0] in_tdata,   // [31:0] instruction, [36:32] reg_index,
                                  // [68:37] write_value, [71:69] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] result_value, [35:32] dest_index,
                                  // [36] dest_written, [40:37] status_flags,
                                  // [41] unsupported, [47:42] zero
);
  import dpalu_pkg::*;

  typedef struct packed {
    logic [2:0]       pad;
    logic [DataW-1:0] write_value;
    logic [4:0]       reg_index;
    logic [DataW-1:0] instruction;
  } in_data_t;

  typedef struct packed {
    logic [5:0]       pad;
    logic             unsupported;
    logic [3:0]       status_flags;
    logic             dest_written;
    logic [3:0]       dest_index;
    logic [DataW-1:0] result_value;
  } out_data_t;

  // -------------------------------------------------------------------------
  // handshake
  // -------------------------------------------------------------------------
  in_data_t  in_d;
  logic      in_fire;
  logic      out_adv;
  logic      s1_adv;
  logic      s1_valid_r;
  logic      out_valid_r;
  out_data_t out_r;
  out_data_t out_nxt;

  assign in_d      = in_data_t'(in_tdata);
  assign out_adv   = ~out_valid_r | out_tready;
  assign s1_adv    = s1_valid_r & out_adv;
  assign in_tready = ~s1_valid_r | out_adv;
  assign in_fire   = in_tvalid & in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // -------------------------------------------------------------------------
  // register file: two copies, copy a serves rn and rs, copy b serves rm
  // -------------------------------------------------------------------------
  logic [DataW-1:0]   rf_a_mem [NumRegs];
  logic [DataW-1:0]   rf_b_mem [NumRegs];
  logic [NumRegs-1:0] rf_valid_r;

  logic               wr_en;
  logic [RegIdxW-1:0] wr_addr;
  logic [DataW-1:0]   wr_data;

  logic [RegIdxW-1:0] rd_a0_addr;
  logic [RegIdxW-1:0] rd_a1_addr;
  logic [RegIdxW-1:0] rd_b0_addr;
  logic [DataW-1:0]   rn_data_r;
  logic [DataW-1:0]   rs_data_r;
  logic [DataW-1:0]   rm_data_r;

  // port a0 reads rn for execute and the indexed register otherwise
  assign rd_a0_addr = (cmd_e'(in_tuser) == CMD_EXEC) ? in_d.instruction[19:16]
                                                     : in_d.reg_index[RegIdxW-1:0];
  assign rd_a1_addr = in_d.instruction[11:8];
  assign rd_b0_addr = in_d.instruction[3:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_a_mem[wr_addr] <= wr_data;
      rf_b_mem[wr_addr] <= wr_data;
    end
  end

  // registered reads, write-first so the next item sees this cycle's write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (wr_en && (wr_addr == rd_a0_addr)) begin
        rn_data_r <= wr_data;
      end else begin
        rn_data_r <= rf_valid_r[rd_a0_addr] ? rf_a_mem[rd_a0_addr] : '0;
      end
      if (wr_en && (wr_addr == rd_a1_addr)) begin
        rs_data_r <= wr_data;
      end else begin
        rs_data_r <= rf_valid_r[rd_a1_addr] ? rf_a_mem[rd_a1_addr] : '0;
      end
      if (wr_en && (wr_addr == rd_b0_addr)) begin
        rm_data_r <= wr_data;
      end else begin
        rm_data_r <= rf_valid_r[rd_b0_addr] ? rf_b_mem[rd_b0_addr] : '0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stage register
  // -------------------------------------------------------------------------
  cmd_e             s1_cmd_r;
  logic [DataW-1:0] s1_ins_r;
  logic [4:0]       s1_idx_r;
  logic [DataW-1:0] s1_wv_r;
  logic [3:0]       status_r;
  logic [3:0]       status_nxt;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= cmd_e'(in_tuser);
      s1_ins_r <= in_d.instruction;
      s1_idx_r <= in_d.reg_index;
      s1_wv_r  <= in_d.write_value;
    end
  end

  // -------------------------------------------------------------------------
  // operand 2: rotated immediate or shifted register
  // -------------------------------------------------------------------------
  shift_e           sh_kind;
  logic [7:0]       sh_amount;
  logic [DataW-1:0] sh_value;
  shift_res_t       sh_res;
  alu_res_t         alu_res;

  always_comb begin
    if (s1_ins_r[25]) begin
      // 8-bit immediate rotated right by twice the 4-bit field
      sh_kind   = SH_ROR;
      sh_amount = {3'b000, s1_ins_r[11:8], 1'b0};
      sh_value  = {24'd0, s1_ins_r[7:0]};
    end else begin
      sh_kind   = shift_e'(s1_ins_r[6:5]);
      sh_amount = s1_ins_r[4] ? rs_data_r[7:0] : {3'b000, s1_ins_r[11:7]};
      sh_value  = rm_data_r;
    end
  end

  dpalu_shifter u_shifter (
    .kind   (sh_kind),
    .amount (sh_amount),
    .value  (sh_value),
    .res    (sh_res)
  );

  dpalu_alu u_alu (
    .opcode      (s1_ins_r[24:21]),
    .op_a        (rn_data_r),
    .op_b        (sh_res.value),
    .shift_carry (sh_res.carry),
    .res         (alu_res)
  );

  // -------------------------------------------------------------------------
  // write-back, flags and result
  // -------------------------------------------------------------------------
  logic idx_is_reg;
  logic idx_is_status;

  assign idx_is_reg    = (s1_idx_r < STATUS_IDX);
  assign idx_is_status = (s1_idx_r == STATUS_IDX);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = s1_idx_r[RegIdxW-1:0];
    wr_data    = s1_wv_r;
    status_nxt = status_r;
    out_nxt    = '0;
    unique case (s1_cmd_r)
      CMD_EXEC: begin
        wr_addr              = s1_ins_r[15:12];
        wr_data              = alu_res.value;
        wr_en                = s1_adv & alu_res.supported & alu_res.writes_rd;
        out_nxt.result_value = alu_res.value;
        out_nxt.dest_index   = s1_ins_r[15:12];
        out_nxt.dest_written = alu_res.supported & alu_res.writes_rd;
        out_nxt.unsupported  = ~alu_res.supported;
        // s bit: update n, z, c and keep v
        if (alu_res.supported && s1_ins_r[20]) begin
          status_nxt = {alu_res.value[DataW-1], (alu_res.value == '0),
                        alu_res.carry, status_r[0]};
        end
      end
      CMD_WRITE: begin
        wr_en = s1_adv & idx_is_reg;
        if (idx_is_reg) begin
          out_nxt.result_value = s1_wv_r;
        end else if (idx_is_status) begin
          status_nxt           = s1_wv_r[3:0];
          out_nxt.result_value = {28'd0, s1_wv_r[3:0]};
        end
      end
      CMD_READ: begin
        if (idx_is_reg) begin
          out_nxt.result_value = rn_data_r;
        end else if (idx_is_status) begin
          out_nxt.result_value = {28'd0, status_r};
        end
      end
      default: ;  // unused command code does nothing
    endcase
    out_nxt.status_flags = status_nxt;
  end

  // -------------------------------------------------------------------------
  // control state
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= '0;
      rf_valid_r  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (out_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        status_r <= status_nxt;
      end
      if (wr_en) begin
        rf_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transfer did not reach the stage register");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advancing stage did not load the output register");

  a_status_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(status_r))
    else $error("status word changed without a retiring item");

  a_unsupported_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.unsupported) |-> (!out_r.dest_written &&
                                            (out_r.result_value == '0)))
    else $error("unsupported opcode produced a write or a result");

  a_write_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_valid_r && out_adv && (s1_cmd_r != CMD_READ)))
    else $error("register file written outside a retiring execute or write");

endmodule

// ===== rtl/dpalu_shifter.sv =====
// ----------------------------------------------------------------------------
// dpalu_shifter: barrel shifter for the second operand
// lsl, lsr, asr and ror by an 8-bit amount, with the shifter carry-out.
// ----------------------------------------------------------------------------
module dpalu_shifter (
  input  dpalu_pkg::shift_e               kind,
  input  logic [7:0]                      amount,
  input  logic [dpalu_pkg::DataW-1:0]     value,
  output dpalu_pkg::shift_res_t           res
);
  import dpalu_pkg::*;

  logic               big;
  logic [5:0]         lin_amt;
  logic [2*DataW-1:0] lsl_w;
  logic [2*DataW-1:0] lsr_w;
  logic [2*DataW-1:0] asr_w;
  logic [2*DataW-1:0] ror_w;

  // amounts of 32 and above saturate at 32 for the linear shifts
  assign big     = (amount > 8'd32);
  assign lin_amt = (amount >= 8'd32) ? 6'd32 : amount[5:0];

  assign lsl_w = {{DataW{1'b0}}, value} << lin_amt;
  assign lsr_w = {value, {DataW{1'b0}}} >> lin_amt;
  assign asr_w = $signed({value, {DataW{1'b0}}}) >>> lin_amt;
  assign ror_w = {value, value} >> amount[4:0];

  always_comb begin
    unique case (kind)
      SH_LSL: begin
        res.value = big ? '0 : lsl_w[DataW-1:0];
        res.carry = big ? 1'b0 : lsl_w[DataW];
      end
      SH_LSR: begin
        res.value = big ? '0 : lsr_w[2*DataW-1:DataW];
        res.carry = big ? 1'b0 : lsr_w[DataW-1];
      end
      SH_ASR: begin
        res.value = asr_w[2*DataW-1:DataW];
        res.carry = asr_w[DataW-1];
      end
      SH_ROR: begin
        // carry is the new bit 31, except for no rotation at all
        res.value = ror_w[DataW-1:0];
        res.carry = (amount != 8'd0) & ror_w[DataW-1];
      end
    endcase
  end

endmodule

// ===== rtl/dpalu_alu.sv =====
// ----------------------------------------------------------------------------
// dpalu_alu: data-processing operations
// Ten supported opcodes with the carry each one produces.
// ----------------------------------------------------------------------------
module dpalu_alu (
  input  logic [3:0]                      opcode,
  input  logic [dpalu_pkg::DataW-1:0]     op_a,
  input  logic [dpalu_pkg::DataW-1:0]     op_b,
  input  logic                            shift_carry,
  output dpalu_pkg::alu_res_t             res
);
  import dpalu_pkg::*;

  logic [DataW:0] sum;
  logic [DataW:0] a_minus_b;
  logic [DataW:0] b_minus_a;

  assign sum       = {1'b0, op_a} + {1'b0, op_b};
  assign a_minus_b = {1'b0, op_a} - {1'b0, op_b};
  assign b_minus_a = {1'b0, op_b} - {1'b0, op_a};

  always_comb begin
    res.value     = '0;
    res.carry     = shift_carry;
    res.writes_rd = 1'b0;
    res.supported = 1'b1;
    unique case (opcode)
      OP_AND: begin res.value = op_a & op_b; res.writes_rd = 1'b1; end
      OP_EOR: begin res.value = op_a ^ op_b; res.writes_rd = 1'b1; end
      OP_ORR: begin res.value = op_a | op_b; res.writes_rd = 1'b1; end
      OP_MOV: begin res.value = op_b;        res.writes_rd = 1'b1; end
      OP_TST: res.value = op_a & op_b;
      OP_TEQ: res.value = op_a ^ op_b;
      OP_SUB: begin
        // carry set means no borrow
        res.value     = a_minus_b[DataW-1:0];
        res.carry     = ~a_minus_b[DataW];
        res.writes_rd = 1'b1;
      end
      OP_CMP: begin
        res.value = a_minus_b[DataW-1:0];
        res.carry = ~a_minus_b[DataW];
      end
      OP_RSB: begin
        res.value     = b_minus_a[DataW-1:0];
        res.carry     = ~b_minus_a[DataW];
        res.writes_rd = 1'b1;
      end
      OP_ADD: begin
        res.value     = sum[DataW-1:0];
        res.carry     = sum[DataW];
        res.writes_rd = 1'b1;
      end
      default: begin
        res.carry     = 1'b0;
        res.supported = 1'b0;
      end
    endcase
  end

endmodule

// ===== verif/dpalu_checker.sv =====
// ----------------------------------------------------------------------------
// dpalu_checker: result predictor and comparator for the alu stage
// Watches both stream channels, keeps its own register file and nzcv word,
// predicts one result per accepted command and compares it field by field
// against the oldest pending prediction when a result transfer happens.
// ----------------------------------------------------------------------------
module dpalu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [71:0] in_tdata,   // [31:0] instruction, [36:32] reg_index,
                                  // [68:37] write_value, [71:69] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // [31:0] result_value, [35:32] dest_index,
                                  // [36] dest_written, [40:37] status_flags,
                                  // [41] unsupported, [47:42] zero
  output int          fail_count,
  output int          pending_results
);
  import dpalu_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  rd;
    logic        written;
    logic [3:0]  nzcv;
    logic        unsup;
  } dp_result_t;

  logic [31:0] gpr [16];
  logic [3:0]  nzcv_q;
  dp_result_t  expected_q [$];
  int          mismatches = 0;
  int          result_num = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d, %s: got 0x%h, expected 0x%h",
             result_num, what, got, want);
    mismatches++;
  endtask

  function automatic shift_res_t barrel_shift(shift_e kind, logic [7:0] amt,
                                              logic [31:0] v);
    shift_res_t r;
    int         n;
    int         m;
    n = int'(amt);
    m = n % 32;
    r.value = v;
    r.carry = 1'b0;
    // shift or rotate by zero passes the value through with carry clear
    if (n != 0) begin
      case (kind)
        SH_LSL: begin
          if (n < 32) begin
            r.value = v << n;
            r.carry = v[32-n];
          end else begin
            r.value = '0;
            r.carry = (n == 32) ? v[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (n < 32) begin
            r.value = v >> n;
            r.carry = v[n-1];
          end else begin
            r.value = '0;
            r.carry = (n == 32) ? v[31] : 1'b0;
          end
        end
        SH_ASR: begin
          r.value = $unsigned($signed(v) >>> n);
          r.carry = (n < 32) ? v[n-1] : v[31];
        end
        SH_ROR: begin
          // whole turns leave the value alone and carry out bit 31
          if (m == 0) begin
            r.carry = v[31];
          end else begin
            r.value = (v >> m) | (v << (32 - m));
            r.carry = v[m-1];
          end
        end
      endcase
    end
    return r;
  endfunction

  // applies one command to the local state and returns the result it causes
  function automatic dp_result_t execute_command(logic [1:0] cmd, logic [31:0] ins,
                                                 logic [4:0] idx, logic [31:0] wv);
    dp_result_t  r;
    shift_res_t  op2;
    logic [3:0]  op;
    logic [31:0] a;
    logic [32:0] sum;
    logic [7:0]  amt;
    logic        carry;
    logic        valid;
    r = '0;
    case (cmd)
      CMD_EXEC: begin
        op = ins[24:21];
        a = gpr[ins[19:16]];
        r.rd = ins[15:12];
        valid = 1'b1;
        if (ins[25]) begin
          op2 = barrel_shift(SH_ROR, {3'b000, ins[11:8], 1'b0}, {24'd0, ins[7:0]});
        end else begin
          amt = ins[4] ? gpr[ins[11:8]][7:0] : {3'b000, ins[11:7]};
          op2 = barrel_shift(shift_e'(ins[6:5]), amt, gpr[ins[3:0]]);
        end
        carry = op2.carry;
        case (op)
          OP_AND, OP_TST: r.value = a & op2.value;
          OP_EOR, OP_TEQ: r.value = a ^ op2.value;
          OP_ORR:         r.value = a | op2.value;
          OP_MOV:         r.value = op2.value;
          OP_SUB, OP_CMP: begin
            r.value = a - op2.value;
            carry = (a >= op2.value);
          end
          OP_RSB: begin
            r.value = op2.value - a;
            carry = (op2.value >= a);
          end
          OP_ADD: begin
            sum = {1'b0, a} + {1'b0, op2.value};
            r.value = sum[31:0];
            carry = sum[32];
          end
          default: valid = 1'b0;
        endcase
        r.written = valid && op != OP_TST && op != OP_TEQ && op != OP_CMP;
        if (!valid) begin
          r.value = '0;
          r.unsup = 1'b1;
        end else begin
          if (r.written) gpr[r.rd] = r.value;
          // v is kept, n z c follow the result
          if (ins[20]) nzcv_q = {r.value[31], r.value == 32'd0, carry, nzcv_q[0]};
        end
      end
      CMD_WRITE, CMD_READ: begin
        if (cmd == CMD_WRITE) begin
          if (idx < STATUS_IDX) gpr[idx[3:0]] = wv;
          else if (idx == STATUS_IDX) nzcv_q = wv[3:0];
        end
        if (idx < STATUS_IDX) r.value = gpr[idx[3:0]];
        else if (idx == STATUS_IDX) r.value = {28'd0, nzcv_q};
      end
      default: ;
    endcase
    r.nzcv = nzcv_q;
    return r;
  endfunction

  always @(posedge clk) begin
    dp_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) gpr[i] = '0;
      nzcv_q = '0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(execute_command(in_tuser, in_tdata[31:0],
                                             in_tdata[36:32], in_tdata[68:37]));
      if (out_tvalid && out_tready) begin
        result_num++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[31:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch("result_value", out_tdata[31:0], want.value);
          if (out_tdata[35:32] !== want.rd)
            report_mismatch("dest_index", 32'(out_tdata[35:32]), 32'(want.rd));
          if (out_tdata[36] !== want.written)
            report_mismatch("dest_written", 32'(out_tdata[36]), 32'(want.written));
          if (out_tdata[40:37] !== want.nzcv)
            report_mismatch("status_flags", 32'(out_tdata[40:37]), 32'(want.nzcv));
          if (out_tdata[41] !== want.unsup)
            report_mismatch("unsupported", 32'(out_tdata[41]), 32'(want.unsup));
        end
      end
    end
    pending_results <= expected_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for data_processing_alu_with_shifter
// Drives directed and random commands (executes, register and status
// writes and reads, unused codes) through three sender/receiver stall mixes; a checker
// beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module testbench;
  import dpalu_pkg::*;

  localparam int         ITEMS        = 1450;
  localparam int         STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int         DRAIN_CYCLES = 8;     // pipeline is two deep
  // command code outside the three the block knows
  localparam logic [1:0] CMD_NONE     = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;   // [1:0] command
  logic [71:0] in_tdata   = '0;   // [31:0] instruction, [36:32] reg_index,
                                  // [68:37] write_value, [71:69] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // [31:0] result_value, [35:32] dest_index,
                                  // [36] dest_written, [40:37] status_flags,
                                  // [41] unsupported, [47:42] zero

  int fail_count;
  int pending_results;

  // idle odds in percent, sender side and receiver side
  int send_idle = 26;
  int recv_idle = 82;

  int useful_items = 0;
  int n_exec       = 0;
  int n_write      = 0;
  int n_read       = 0;
  int n_idle_cmd   = 0;
  int stall_cycles = 0;

  logic [3:0] alu_ops [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                               OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};

  always #10 clk = ~clk;

  data_processing_alu_with_shifter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dpalu_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] ins,
                          input logic [4:0] idx, input logic [31:0] wv);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, wv, idx, ins};
    do @(posedge clk); while (!in_tready);
    case (cmd)
      CMD_EXEC:  n_exec++;
      CMD_WRITE: n_write++;
      CMD_READ:  n_read++;
      default:   n_idle_cmd++;
    endcase
    // idle commands and writes to a bad index change nothing
    if (cmd != CMD_NONE && !(cmd == CMD_WRITE && idx > STATUS_IDX)) useful_items++;
  endtask

  // sender holds off until every predicted result has been seen
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // watchdog: ends the run when the channels stay quiet too long
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---------------- directed part ----------------
    // operand registers: most negative, most positive, shift amount of 32
    send_cmd(CMD_WRITE, $urandom, 5'd1, 32'h8000_0000);
    send_cmd(CMD_WRITE, $urandom, 5'd2, 32'h7fff_ffff);
    send_cmd(CMD_WRITE, $urandom, 5'd5, 32'd32);
    // status write keeps only the low nibble, so v is set from here on
    send_cmd(CMD_WRITE, $urandom, STATUS_IDX, 32'hffff_ffff);
    // index above the status word: write ignored, reads give zero
    send_cmd(CMD_WRITE, $urandom, 5'd31, 32'h1234_5678);
    send_cmd(CMD_READ, $urandom, STATUS_IDX, $urandom);
    send_cmd(CMD_READ, $urandom, 5'd17, $urandom);
    send_cmd(CMD_NONE, $urandom, 5'($urandom), $urandom);
    // every opcode with s set: even ones shift r2 by r5 (32) with each
    // shift kind, odd ones take 0xff rotated by twice the opcode
    for (int op = 0; op < 16; op++) begin
      logic [31:0] ins;
      ins = {4'hE, 2'b00, op[0], op[3:0], 1'b1, 4'd1, ~op[3:0], 12'h000};
      if (op[0]) ins[11:0] = {op[3:0], 8'hff};
      else       ins[11:0] = {4'd5, 1'b0, op[2:1], 1'b1, 4'd2};
      send_cmd(CMD_EXEC, ins, 5'($urandom), $urandom);
    end
    // zero immediate with no rotation: result zero, carry clear
    send_cmd(CMD_EXEC, {4'hE, 2'b00, 1'b1, OP_MOV, 1'b1, 4'd0, 4'd9, 12'h000},
             5'($urandom), $urandom);

    // ---------------- random part, three stall mixes ----------------
    for (int phase = 0; phase < 3; phase++) begin
      // full drain between mixes
      wait_results_done();
      case (phase)
        0: begin send_idle = 26; recv_idle <= 82; end
        1: begin send_idle = 82; recv_idle <= 26; end
        default: begin send_idle = 0; recv_idle <= 0; end
      endcase
      phase_target = useful_items + ITEMS / 3;
      while (useful_items < phase_target) begin
        logic [31:0] ins;
        logic [31:0] wv;
        logic [4:0]  idx;
        int          pick;
        ins  = $urandom;
        wv   = $urandom;
        pick = $urandom_range(0, 99);
        // mostly handled opcodes, some of the six unhandled ones
        if ($urandom_range(0, 9) != 0) ins[24:21] = alu_ops[$urandom_range(0, 9)];
        case ($urandom_range(0, 19))
          0, 1, 2: idx = STATUS_IDX;
          3, 4:    idx = 5'($urandom_range(17, 31));
          default: idx = 5'($urandom_range(0, 15));
        endcase
        // register values that steer shifts and arithmetic into corners
        case ($urandom_range(0, 9))
          0: wv = '0;
          1: wv = '1;
          2: wv = 32'h8000_0000;
          3: wv = 32'h7fff_ffff;
          4, 5, 6: begin
            case ($urandom_range(0, 7))
              0: wv[7:0] = 8'd0;
              1: wv[7:0] = 8'd1;
              2: wv[7:0] = 8'd31;
              3: wv[7:0] = 8'd32;
              4: wv[7:0] = 8'd33;
              5: wv[7:0] = 8'd64;
              6: wv[7:0] = 8'd160;
              default: wv[7:0] = 8'd255;
            endcase
          end
          default: ;
        endcase
        if (pick < 62)      send_cmd(CMD_EXEC, ins, idx, wv);
        else if (pick < 80) send_cmd(CMD_WRITE, ins, idx, wv);
        else if (pick < 97) send_cmd(CMD_READ, ins, idx, wv);
        else                send_cmd(CMD_NONE, ins, idx, wv);
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d executes, %0d register writes, %0d reads, %0d no-op commands",
             n_exec, n_write, n_read, n_idle_cmd);
    $display("over three stall mixes on both channels with a full drain between them");
    if (fail_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
